// ===== hdl/elcs_pkg.sv =====
// shared types and constants for the edge length cdf sampler
package elcs_pkg;

  localparam int MaxEdgesDefault  = 1024;
  localparam int CoordBitsDefault = 24;
  localparam int FieldBits = 24;
  localparam int LenBits   = 25;
  localparam int TotBits   = 35;
  localparam int IdxBits   = 10;
  localparam int DrawBits  = 16;
  localparam int SqBits    = 50;

  localparam logic [1:0] ActNew    = 2'd0;
  localparam logic [1:0] ActAppend = 2'd1;
  localparam logic [1:0] ActSample = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SUM, S_ROOT, S_STORE, S_PROD, S_SRCH, S_WAITRD, S_FETCH, S_FINAL, S_OUT
  } elcs_state_t;

  typedef struct packed {
    logic load_in;
    logic sq_step;
    logic sq_sum;
    logic root_init;
    logic root_step;
    logic store;
    logic prod;
    logic srch_init;
    logic srch_rd;
    logic srch_upd;
    logic fetch;
    logic fin_load;
    logic fin_sample;
    logic fin_misc;
  } elcs_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       root_done;
    logic       srch_done;
  } elcs_sts_t;

endpackage

// ===== hdl/elcs_ctrl.sv =====
// controller state machine for the edge length cdf sampler
module elcs_ctrl import elcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  elcs_sts_t sts,
  output elcs_cmd_t cmd
);

  elcs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SQ;
      S_SQ: begin
        priority if (sts.action == ActSample) state_nxt = sts.empty ? S_FINAL : S_PROD;
        else if (sts.action == ActNew || sts.action == ActAppend)
          state_nxt = sts.full ? S_FINAL : S_SUM;
        else state_nxt = S_FINAL;
      end
      S_SUM:   state_nxt = S_ROOT;
      S_ROOT:  if (sts.root_done) state_nxt = S_STORE;
      S_STORE: state_nxt = S_OUT;
      S_PROD:  state_nxt = S_SRCH;
      S_SRCH:  state_nxt = sts.srch_done ? S_FETCH : S_WAITRD;
      S_WAITRD: state_nxt = S_SRCH;
      S_FETCH: state_nxt = S_FINAL;
      S_FINAL: state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
      end
      S_SUM:  begin
        cmd.sq_sum = 1'b1;
        cmd.root_init = 1'b1;
      end
      S_ROOT:   cmd.root_step = 1'b1;
      S_STORE:  cmd.store = 1'b1;
      S_PROD: begin
        cmd.prod = 1'b1;
        cmd.srch_init = 1'b1;
      end
      S_SRCH:   cmd.srch_rd = !sts.srch_done;
      S_WAITRD: cmd.srch_upd = 1'b1;
      S_FETCH:  cmd.fetch = 1'b1;
      S_FINAL: begin
        priority if (sts.action == ActSample) cmd.fin_sample = 1'b1;
        else if ((sts.action == ActNew || sts.action == ActAppend) && sts.full)
          cmd.fin_load = 1'b1;
        else cmd.fin_misc = 1'b1;
      end
      S_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hdl/elcs_dp.sv =====
// datapath: squared distance, iterative root, prefix memories, binary search
module elcs_dp import elcs_pkg::*; #(
  parameter int MAX_EDGES  = MaxEdgesDefault,
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  elcs_cmd_t                   cmd,
  output elcs_sts_t                   sts,
  input  logic [1:0]                  in_action,
  input  logic signed [FieldBits-1:0] in_end_a_x,
  input  logic signed [FieldBits-1:0] in_end_a_y,
  input  logic signed [FieldBits-1:0] in_end_a_z,
  input  logic signed [FieldBits-1:0] in_end_b_x,
  input  logic signed [FieldBits-1:0] in_end_b_y,
  input  logic signed [FieldBits-1:0] in_end_b_z,
  input  logic [DrawBits-1:0]         in_draw,
  output logic [1:0]                  out_status,
  output logic [IdxBits-1:0]          out_edge_index,
  output logic [LenBits-1:0]          out_edge_length,
  output logic [TotBits-1:0]          out_total_length
);

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int CB = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam int DW = CB + 1;
  localparam logic [TotBits-1:0] TotMax = '1;
  localparam int RootSteps = SqBits / 2;

  logic [1:0] act_r;
  logic [DrawBits-1:0] draw_r;
  logic [DW-1:0] d_r [3];
  logic [SqBits-1:0] sq_r [3];
  logic [SqBits-1:0] n_r, res_r, bit_r;
  logic [4:0] rstep_r;
  logic [CW-1:0] count_r;
  logic [TotBits-1:0] total_r;
  logic [TotBits+DrawBits-1:0] target_r;
  logic [CW-1:0] lo_r, hi_r;
  logic [TotBits-1:0] psum_rd_r;
  logic [LenBits-1:0] len_rd_r;
  logic [TotBits-1:0] psum_mem [MAX_EDGES];
  logic [LenBits-1:0] len_mem [MAX_EDGES];

  logic signed [DW-1:0] ca [3], cb [3];
  logic [CW-1:0] cnt_eff, mid;
  logic [TotBits:0] sum_w;
  logic [TotBits-1:0] sum_sat;
  logic [SqBits-1:0] tr;
  logic [LenBits-1:0] len_w;

  assign ca[0] = DW'($signed(in_end_a_x[CB-1:0]));
  assign ca[1] = DW'($signed(in_end_a_y[CB-1:0]));
  assign ca[2] = DW'($signed(in_end_a_z[CB-1:0]));
  assign cb[0] = DW'($signed(in_end_b_x[CB-1:0]));
  assign cb[1] = DW'($signed(in_end_b_y[CB-1:0]));
  assign cb[2] = DW'($signed(in_end_b_z[CB-1:0]));

  assign cnt_eff = (act_r == ActNew) ? '0 : count_r;
  assign len_w   = res_r[LenBits-1:0];
  assign sum_w   = {1'b0, (act_r == ActNew) ? TotBits'(0) : total_r} + (TotBits+1)'(len_w);
  assign sum_sat = sum_w[TotBits] ? TotMax : sum_w[TotBits-1:0];
  assign tr      = res_r + bit_r;
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);

  assign sts = '{
    action:    act_r,
    full:      (cnt_eff == CW'(MAX_EDGES)),
    empty:     (count_r == '0),
    root_done: (rstep_r == 5'(RootSteps)),
    srch_done: !(lo_r < hi_r)
  };

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= in_action;
      draw_r <= in_draw;
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= (ca[i] > cb[i]) ? DW'(ca[i] - cb[i]) : DW'(cb[i] - ca[i]);
      end
    end
    // the three squares are independent, so each has its own multiplier here
    if (cmd.sq_step) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= SqBits'(d_r[i]) * SqBits'(d_r[i]);
    end
    if (cmd.sq_sum) n_r <= sq_r[0] + sq_r[1] + sq_r[2];
    if (cmd.root_init) begin
      res_r   <= '0;
      bit_r   <= SqBits'(1) << (SqBits - 2);
      rstep_r <= '0;
    end
    if (cmd.root_step && !sts.root_done) begin
      if (n_r >= tr) begin
        n_r   <= n_r - tr;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r   <= bit_r >> 2;
      rstep_r <= rstep_r + 5'd1;
    end
    if (cmd.prod) target_r <= (TotBits+DrawBits)'(draw_r) * (TotBits+DrawBits)'(total_r);
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end
    if (cmd.srch_rd) psum_rd_r <= psum_mem[mid[AW-1:0]];
    if (cmd.srch_upd) begin
      if ({psum_rd_r, DrawBits'(0)} > target_r) hi_r <= mid;
      else lo_r <= mid + CW'(1);
    end
    if (cmd.fetch) begin
      if (lo_r > count_r - CW'(1)) lo_r <= count_r - CW'(1);
      len_rd_r <= len_mem[(lo_r > count_r - CW'(1)) ? AW'(count_r - CW'(1)) : lo_r[AW-1:0]];
    end
    if (cmd.store) begin
      psum_mem[cnt_eff[AW-1:0]] <= sum_sat;
      len_mem[cnt_eff[AW-1:0]]  <= len_w;
      out_status       <= StOk;
      out_edge_index   <= IdxBits'(cnt_eff);
      out_edge_length  <= len_w;
      out_total_length <= sum_sat;
    end
    if (cmd.fin_sample) begin
      out_status       <= sts.empty ? StEmpty : StOk;
      out_edge_index   <= sts.empty ? '0 : IdxBits'(lo_r);
      out_edge_length  <= sts.empty ? '0 : len_rd_r;
      out_total_length <= sts.empty ? '0 : total_r;
    end
    if (cmd.fin_load) begin
      out_status       <= StFull;
      out_edge_index   <= '0;
      out_edge_length  <= '0;
      out_total_length <= (act_r == ActNew) ? '0 : total_r;
    end
    if (cmd.fin_misc) begin
      out_status       <= StOk;
      out_edge_index   <= '0;
      out_edge_length  <= '0;
      out_total_length <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.store) begin
      count_r <= cnt_eff + CW'(1);
      total_r <= sum_sat;
    end else if (cmd.fin_load && act_r == ActNew) begin
      count_r <= '0;
      total_r <= '0;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDGES)) else $error("edge count beyond table");
  a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> count_r == $past(cnt_eff) + CW'(1)) else $error("count not advanced");
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.store && act_r == ActAppend) |=> total_r >= $past(total_r))
    else $error("total decreased on append");
  a_srch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_upd |-> lo_r < hi_r && hi_r <= count_r) else $error("search window bad");
`endif

endmodule

// ===== hdl/edge_length_cdf_sampler.sv =====
// edge length cdf sampler: load edges into a length table, draw indices by length
// Usage:
//   input channel in_valid/in_ready carries one item: action, two end points and
//   a Q0.16 draw. action 0 starts a new table with the edge, 1 appends, 2 samples.
//   output channel out_valid/out_ready returns one result per item: status, edge
//   index, edge length and running total.
// Timing:
//   one item at a time. a load runs the squares, their sum and the 25-step restoring
//   square root, then stores; a sample runs at most s = ceil(log2(count + 1))
//   search steps of one prefix memory read and one compare each, then a length
//   fetch. a full table, empty sample or unused action skips the root and the
//   search. the result is held in the output register until taken and the next
//   item is accepted in the cycle after the transfer.
// Reset:
//   rst_n synchronous active low clears the edge count and total; table
//   memories keep their contents and are only read below the count.
// Stall:
//   a stalled receiver holds the block in its output state with the result
//   stable; in_ready stays low meanwhile.
module edge_length_cdf_sampler import elcs_pkg::*; #(
  parameter int MAX_EDGES  = MaxEdgesDefault,
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic signed [FieldBits-1:0] in_end_a_x,
  input  logic signed [FieldBits-1:0] in_end_a_y,
  input  logic signed [FieldBits-1:0] in_end_a_z,
  input  logic signed [FieldBits-1:0] in_end_b_x,
  input  logic signed [FieldBits-1:0] in_end_b_y,
  input  logic signed [FieldBits-1:0] in_end_b_z,
  input  logic [DrawBits-1:0]         in_draw,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [IdxBits-1:0]          out_edge_index,
  output logic [LenBits-1:0]          out_edge_length,
  output logic [TotBits-1:0]          out_total_length
);

  elcs_cmd_t cmd;
  elcs_sts_t sts;

  elcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  elcs_dp #(.MAX_EDGES(MAX_EDGES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action),
    .in_end_a_x(in_end_a_x), .in_end_a_y(in_end_a_y), .in_end_a_z(in_end_a_z),
    .in_end_b_x(in_end_b_x), .in_end_b_y(in_end_b_y), .in_end_b_z(in_end_b_z),
    .in_draw(in_draw),
    .out_status(out_status), .out_edge_index(out_edge_index),
    .out_edge_length(out_edge_length), .out_total_length(out_total_length)
  );

endmodule

// ===== test/tb.sv =====
// testbench for the edge length cdf sampler: directed table, a full-table fill, then random loads and samples
`timescale 1ns / 1ps
module tb;
  import elcs_pkg::*;

  localparam int MaxEdges = MaxEdgesDefault;
  localparam int CycleLimit = 1500000;
  localparam logic [34:0] TotalMax = 35'h7_FFFF_FFFF;
  localparam logic [1:0] ActSpare = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic signed [23:0] ax, ay, az, bx, by, bz;
    logic [15:0] draw;
  } edge_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] idx;
    logic [24:0] len;
    logic [34:0] total;
  } sample_res_t;

  typedef struct {
    edge_item_t item;
    logic typed;  // expected result given in the row
    sample_res_t res;
  } table_row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] in_action = 0;
  logic signed [23:0] in_end_a_x = 0, in_end_a_y = 0, in_end_a_z = 0;
  logic signed [23:0] in_end_b_x = 0, in_end_b_y = 0, in_end_b_z = 0;
  logic [15:0] in_draw = 0;
  logic [1:0] out_status;
  logic [9:0] out_edge_index;
  logic [24:0] out_edge_length;
  logic [34:0] out_total_length;

  edge_length_cdf_sampler i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [34:0] prefix_mem [MaxEdges];
  logic [24:0] length_mem [MaxEdges];
  int unsigned edge_cnt;
  logic [34:0] run_total;

  sample_res_t expected_q[$];
  int errors, n_loads, n_samples, n_full, n_empty, n_results, cycles;
  bit quiet;  // no idling in the final stretch

  function automatic void queue_expected(sample_res_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic logic [24:0] isqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[24:0];
  endfunction

  function automatic logic [63:0] sq_dist(edge_item_t it);
    longint dx, dy, dz;
    dx = longint'(it.bx) - longint'(it.ax);
    dy = longint'(it.by) - longint'(it.ay);
    dz = longint'(it.bz) - longint'(it.az);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic sample_res_t predict_draw(edge_item_t it);
    sample_res_t r;
    logic [63:0] target, sum;
    logic [24:0] len;
    int unsigned lo, hi, mid;
    r = '{StOk, 10'd0, 25'd0, run_total};
    if (it.action == ActNew || it.action == ActAppend) begin
      if (it.action == ActNew) begin
        edge_cnt = 0;
        run_total = 0;
      end
      if (edge_cnt >= MaxEdges) begin
        r.status = StFull;
        r.total = run_total;
        n_full++;
        return r;
      end
      len = isqrt(sq_dist(it));
      sum = {29'd0, run_total} + len;
      if (sum > TotalMax) sum = TotalMax;
      length_mem[edge_cnt] = len;
      prefix_mem[edge_cnt] = sum[34:0];
      run_total = sum[34:0];
      r.idx = edge_cnt[9:0];
      r.len = len;
      r.total = run_total;
      edge_cnt++;
      n_loads++;
    end else if (it.action == ActSample) begin
      if (edge_cnt == 0) begin
        n_empty++;
        return '{StEmpty, 10'd0, 25'd0, 35'd0};
      end
      target = 64'(it.draw) * run_total;
      lo = 0;
      hi = edge_cnt;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if ((64'(prefix_mem[mid]) << 16) > target) hi = mid;
        else lo = mid + 1;
      end
      if (lo > edge_cnt - 1) lo = edge_cnt - 1;
      r.idx = lo[9:0];
      r.len = length_mem[lo];
      n_samples++;
    end
    return r;
  endfunction

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return $signed(24'($urandom));
      1: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
      default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  function automatic edge_item_t rand_item();
    edge_item_t it;
    int mode, pick;
    mode = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0);
    it.ax = rand_coord(mode);
    it.ay = rand_coord(mode);
    it.az = $urandom_range(0, 2) == 0 ? 24'sd0 : rand_coord(mode);
    it.bx = rand_coord(mode);
    it.by = rand_coord(mode);
    it.bz = $urandom_range(0, 2) == 0 ? 24'sd0 : rand_coord(mode);
    it.draw = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                        : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) it.action = ActNew;
    else if (pick < 45) it.action = ActAppend;
    else if (pick < 97) it.action = ActSample;
    else it.action = ActSpare;
    return it;
  endfunction

  // valid stays up from one transfer to the next unless an idle gap is drawn
  task automatic send_item(edge_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_action <= it.action;
    in_end_a_x <= it.ax;
    in_end_a_y <= it.ay;
    in_end_a_z <= it.az;
    in_end_b_x <= it.bx;
    in_end_b_y <= it.by;
    in_end_b_z <= it.bz;
    in_draw <= it.draw;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // receiver stalls in bursts
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        stall = $urandom_range(1, 9);
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    sample_res_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_edge_index, out_edge_length, out_total_length};
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no transfer pending: %p", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, got.status);
          errors++;
        end
        if (got.idx !== exp_r.idx) begin
          $display("%0t: edge_index expected %0d actual %0d", $realtime, exp_r.idx, got.idx);
          errors++;
        end
        if (got.len !== exp_r.len) begin
          $display("%0t: edge_length expected %0d actual %0d", $realtime, exp_r.len, got.len);
          errors++;
        end
        if (got.total !== exp_r.total) begin
          $display("%0t: total_length expected %0d actual %0d", $realtime, exp_r.total,
                   got.total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    edge_item_t it;
    sample_res_t p;
    int drain;
    // 3-4-0 edge gives length 5.0 in fixed point
    rows.insert(rows.size(), '{'{ActSample, 0, 0, 0, 0, 0, 0, 16'h1234}, 1,
                               '{StEmpty, 0, 0, 0}});
    rows.insert(rows.size(), '{'{ActSpare, 0, 0, 0, 0, 0, 0, 0}, 1, '{StOk, 0, 0, 0}});
    rows.insert(rows.size(), '{'{ActNew, 0, 0, 0, 24'sd768, 24'sd1024, 0, 0}, 1,
                               '{StOk, 0, 25'd1280, 35'd1280}});
    rows.insert(rows.size(), '{'{ActAppend, 0, 0, 0, 0, 0, 0, 0}, 1,
                               '{StOk, 1, 0, 35'd1280}});
    rows.insert(rows.size(), '{'{ActSample, 0, 0, 0, 0, 0, 0, 16'h0000}, 0, '0});
    rows.insert(rows.size(), '{'{ActSample, 0, 0, 0, 0, 0, 0, 16'hFFFF}, 0, '0});
    // extreme coordinates, all axes at full range
    rows.insert(rows.size(), '{'{ActAppend, 24'sh800000, 24'sh800000, 24'sh800000,
                                 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0}, 0, '0});
    rows.insert(rows.size(), '{'{ActAppend, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                                 24'sh800000, 24'sh7FFFFF, 24'sh800000, 0}, 0, '0});
    rows.insert(rows.size(), '{'{ActSample, 0, 0, 0, 0, 0, 0, 16'h8000}, 0, '0});
    rows.insert(rows.size(), '{'{ActSpare, 24'sh7FFFFF, 0, 0, 0, 0, 0, 16'hFFFF}, 0, '0});
    // zero total: every stored length zero, clamp to last edge
    rows.insert(rows.size(), '{'{ActNew, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 0},
                               1, '{StOk, 0, 0, 0}});
    rows.insert(rows.size(), '{'{ActAppend, 0, 0, 0, 0, 0, 0, 0}, 1, '{StOk, 1, 0, 0}});
    rows.insert(rows.size(), '{'{ActSample, 0, 0, 0, 0, 0, 0, 16'h4000}, 1,
                               '{StOk, 1, 0, 0}});
    rows.insert(rows.size(), '{'{ActSample, 0, 0, 0, 0, 0, 0, 16'h0}, 1, '{StOk, 1, 0, 0}});

    repeat (12) @(negedge clk);
    rst_n <= 1;
    edge_cnt = 0;
    run_total = 0;

    foreach (rows[i]) begin
      p = predict_draw(rows[i].item);
      queue_expected(rows[i].typed ? rows[i].res : p);
      send_item(rows[i].item);
    end

    // fill the table until loads are dropped, long edges push the total near its top
    it = '{ActNew, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
           24'sh7FFFFF, 0};
    for (int k = 0; k < MaxEdges + 3; k++) begin
      if (k > 0) it.action = ActAppend;
      if (k % 200 == 0) it.draw = 16'($urandom);
      queue_expected(predict_draw(it));
      send_item(it);
      if (k % 97 == 0) begin
        edge_item_t s;
        s = rand_item();
        s.action = ActSample;
        queue_expected(predict_draw(s));
        send_item(s);
      end
    end

    for (int k = 0; k < 800; k++) begin
      if (k == 650) quiet = 1;
      it = rand_item();
      queue_expected(predict_draw(it));
      send_item(it);
    end
    in_valid <= 0;

    drain = 0;
    while (expected_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d loads, %0d samples, %0d full-table drops, %0d empty samples",
             n_loads, n_samples, n_full, n_empty);
    $display("%0d results checked, %0d mismatches", n_results, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
